>>> design/sgpa_pkg.sv
// Shared constants, types and codes of the streaming graph partition assigner.
package sgpa_pkg;

  localparam int PARTS    = 8;
  localparam int VERTICES = 65536;

  localparam int PW  = $clog2(PARTS);
  localparam int NW  = $clog2(PARTS + 1);
  localparam int MW  = $clog2(PARTS + 1);
  localparam int VW  = $clog2(VERTICES);

  localparam int ID_W    = 16;
  localparam int CNT_W   = 16;
  localparam int SIZE_W  = 17;
  localparam int EDGE_W  = 32;
  localparam int ALPHA_W = 16;
  localparam int NPART_W = 4;
  localparam int CFG_W   = 16;
  localparam int PROD_W  = ALPHA_W + SIZE_W + 1;
  localparam int SCORE_W = PROD_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REQ_NEIGHBOR = 2'd0;
  localparam logic [1:0] REQ_SEED     = 2'd1;
  localparam logic [1:0] REQ_EMPTY    = 2'd2;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_PARTS = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd128;
  localparam logic [NPART_W-1:0] PARTS_RESET = 4'd5;

  typedef enum logic [1:0] {
    K_NEIGHBOR,
    K_SEED,
    K_EMPTY
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] vertex;
    logic            vertex_ok;
    logic [VW-1:0]   nb_addr;
    logic            nb_ok;
    logic            last;
    logic [PW-1:0]   part;
  } item_t;

endpackage

>>> design/sgpa_front.sv
// Front end: accepts input words, classifies them and hands them to the queue.
module sgpa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_req_type_i,
  input  logic [15:0]          in_vertex_id_i,
  input  logic [15:0]          in_neighbor_id_i,
  input  logic                 in_last_neighbor_i,
  input  logic [2:0]           in_seed_partition_i,
  input  logic                 clearing_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sgpa_pkg::item_t      q_item_o
);
  import sgpa_pkg::*;

  logic              fv_q, fv_d;
  item_t             item_q, item_d;
  logic              accept;
  logic              keep;
  logic [VW+15:0]    nb_ext;
  logic [PW+2:0]     seed_ext;

  assign in_stall_o = clearing_i | (fv_q & q_full_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = fv_q;
  assign q_item_o   = item_q;
  assign nb_ext     = {{VW{1'b0}}, in_neighbor_id_i};
  assign seed_ext   = {{PW{1'b0}}, in_seed_partition_i};

  always_comb begin
    item_d           = item_q;
    keep             = 1'b0;
    item_d.kind      = K_NEIGHBOR;
    item_d.vertex    = in_vertex_id_i;
    item_d.vertex_ok = (32'(in_vertex_id_i) < VERTICES);
    item_d.nb_addr   = nb_ext[VW-1:0];
    item_d.nb_ok     = (32'(in_neighbor_id_i) < VERTICES);
    item_d.last      = in_last_neighbor_i;
    item_d.part      = seed_ext[PW-1:0];
    case (in_req_type_i)
      REQ_NEIGHBOR: begin
        item_d.kind = K_NEIGHBOR;
        keep        = 1'b1;
      end
      REQ_SEED: begin
        item_d.kind = K_SEED;
        keep        = (32'(in_seed_partition_i) < PARTS);
      end
      REQ_EMPTY: begin
        item_d.kind = K_EMPTY;
        keep        = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    fv_d = fv_q;
    if (fv_q && !q_full_i) begin
      fv_d = 1'b0;
    end
    if (accept) begin
      fv_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

>>> design/sgpa_queue.sv
// Short queue of classified words between the front and back ends.
module sgpa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sgpa_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sgpa_pkg::item_t item_o
);
  import sgpa_pkg::*;

  item_t          slot_q [QUEUE_DEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   fill_q, fill_d;
  logic           do_push, do_pop;

  assign full_o  = (fill_q == (QAW+1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (do_push) begin
        wptr_q <= (wptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

>>> design/sgpa_back.sv
// Back end: membership store, partition counters, cost scan and placement.
module sgpa_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [sgpa_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         q_valid_i,
  input  sgpa_pkg::item_t              q_item_i,
  output logic                         q_pop_o,
  output logic                         clearing_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [15:0]                  out_placed_vertex_o,
  output logic [2:0]                   out_chosen_partition_o,
  output logic [15:0]                  out_neighbors_inside_o,
  output logic [16:0]                  out_partition_size_o,
  output logic [31:0]                  out_inside_edge_total_o
);
  import sgpa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_PLACE = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [ALPHA_W-1:0]  alpha_q;
  logic [NPART_W-1:0]  parts_q;
  logic [CNT_W-1:0]    cnt_q  [PARTS];
  logic [SIZE_W-1:0]   size_q [PARTS];
  logic [EDGE_W-1:0]   edge_q [PARTS];
  item_t               cur_q;
  logic [PW-1:0]       best_q;
  logic signed [SCORE_W-1:0] best_score_q;
  logic [NW-1:0]       idx_q;
  logic                pv_q;
  logic [NW-1:0]       pidx_q;
  logic [PROD_W-1:0]   prod_q;
  logic [CNT_W-1:0]    pcnt_q;
  logic                clearing_q;
  logic [VW-1:0]       clr_q;
  logic [MW-1:0]       mem [VERTICES];
  logic [MW-1:0]       rd_q;
  logic                out_valid_q;
  logic [15:0]         out_vertex_q;
  logic [2:0]          out_part_q;
  logic [15:0]         out_inside_q;
  logic [16:0]         out_size_q;
  logic [31:0]         out_edge_q;

  logic [NW-1:0]       n_eff;
  logic [PW-1:0]       sel_p;
  logic [CNT_W-1:0]    sel_cnt;
  logic [SIZE_W-1:0]   sel_size;
  logic [EDGE_W-1:0]   sel_edge;
  logic                pop;
  logic                issue;
  logic                scan_done;
  logic                place_go;
  logic                look_inc;
  logic [MW-1:0]       qidx;
  logic signed [SCORE_W-1:0] score;
  logic [SIZE_W-1:0]   new_size;
  logic [EDGE_W:0]     edge_sum;
  logic [EDGE_W-1:0]   new_edge;
  logic [PW+2:0]       best_ext;
  logic [VW+15:0]      v_ext;
  logic                mem_we;
  logic [VW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata;

  always_comb begin
    if (parts_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(parts_q) > PARTS) begin
      n_eff = NW'(PARTS);
    end else begin
      n_eff = NW'(parts_q);
    end
  end

  assign sel_p    = (state_q == ST_PLACE) ? best_q : idx_q[PW-1:0];
  assign sel_cnt  = cnt_q[sel_p];
  assign sel_size = size_q[sel_p];
  assign sel_edge = edge_q[best_q];

  assign pop       = (state_q == ST_IDLE) & q_valid_i & ~clearing_q;
  assign q_pop_o   = pop;
  assign issue     = (state_q == ST_SCAN) & (idx_q < n_eff);
  assign scan_done = pv_q & (pidx_q == n_eff - NW'(1));
  assign place_go  = (state_q == ST_PLACE) & (~out_valid_q | ~out_stall_i);
  assign qidx      = rd_q - MW'(1);
  assign look_inc  = (state_q == ST_LOOK) & cur_q.nb_ok & (rd_q != '0) &
                     (32'(qidx) < PARTS);

  assign score = $signed({{(SCORE_W-CNT_W-8){1'b0}}, pcnt_q, 8'b0}) -
                 $signed({2'b0, prod_q});

  assign new_size = (sel_size == '1) ? sel_size : sel_size + 1'b1;
  assign edge_sum = {1'b0, sel_edge} + (EDGE_W+1)'(sel_cnt);
  assign new_edge = edge_sum[EDGE_W] ? '1 : edge_sum[EDGE_W-1:0];
  assign best_ext = {3'b0, best_q};
  assign v_ext    = {{VW{1'b0}}, cur_q.vertex};

  assign mem_we    = clearing_q | (place_go & cur_q.vertex_ok);
  assign mem_waddr = clearing_q ? clr_q : v_ext[VW-1:0];
  assign mem_wdata = clearing_q ? '0 : MW'(best_q) + MW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (q_item_i.kind)
            K_NEIGHBOR: state_d = ST_LOOK;
            K_SEED:     state_d = ST_PLACE;
            K_EMPTY:    state_d = ST_SCAN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOK:  state_d = cur_q.last ? ST_SCAN : ST_IDLE;
      ST_SCAN:  state_d = scan_done ? ST_PLACE : ST_SCAN;
      ST_PLACE: state_d = place_go ? ST_IDLE : ST_PLACE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alpha_q     <= ALPHA_RESET;
      parts_q     <= PARTS_RESET;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      best_q      <= '0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < PARTS; p++) begin
        cnt_q[p]  <= '0;
        size_q[p] <= '0;
        edge_q[p] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALPHA: alpha_q <= cfg_data_i[ALPHA_W-1:0];
          CFG_PARTS: parts_q <= cfg_data_i[NPART_W-1:0];
          default:   alpha_q <= alpha_q;
        endcase
      end

      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == VW'(VERTICES - 1)) begin
          clearing_q <= 1'b0;
        end
      end

      if (pop && q_item_i.kind == K_SEED) begin
        best_q <= q_item_i.part;
      end
      if ((pop && q_item_i.kind == K_EMPTY) || (state_q == ST_LOOK && cur_q.last)) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
      end

      pv_q <= issue;
      if (issue) begin
        pidx_q <= idx_q;
      end
      if (pv_q && (pidx_q == '0 || score > best_score_q)) begin
        best_q <= pidx_q[PW-1:0];
      end

      for (int p = 0; p < PARTS; p++) begin
        if ((pop && q_item_i.kind != K_NEIGHBOR) || place_go) begin
          cnt_q[p] <= '0;
        end else if (look_inc && qidx == MW'(p) && cnt_q[p] != '1) begin
          cnt_q[p] <= cnt_q[p] + 1'b1;
        end
        if (place_go && best_q == PW'(p)) begin
          size_q[p] <= new_size;
          edge_q[p] <= new_edge;
        end
      end

      if (place_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_item_i;
    end
    if (issue) begin
      prod_q <= alpha_q * {sel_size, 1'b1};
      pcnt_q <= sel_cnt;
    end
    if (pv_q && (pidx_q == '0 || score > best_score_q)) begin
      best_score_q <= score;
    end
    if (place_go) begin
      out_vertex_q <= cur_q.vertex;
      out_part_q   <= best_ext[2:0];
      out_inside_q <= sel_cnt;
      out_size_q   <= new_size;
      out_edge_q   <= new_edge;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[q_item_i.nb_addr];
  end

  assign clearing_o              = clearing_q;
  assign out_valid_o             = out_valid_q;
  assign out_placed_vertex_o     = out_vertex_q;
  assign out_chosen_partition_o  = out_part_q;
  assign out_neighbors_inside_o  = out_inside_q;
  assign out_partition_size_o    = out_size_q;
  assign out_inside_edge_total_o = out_edge_q;

endmodule

>>> design/streaming_graph_partition_assign.sv
// Top level of the streaming graph partition assigner.
// After reset the block clears every entry of its membership store, and holds
// in_stall_o high until that pass is over. A word then enters a one-word front
// register and a four-word queue. For a neighbour word the back-end sequencer
// does one membership memory read and one counter update; a last neighbour and a
// vertex without neighbours then go through the cost scan, which runs one
// partition per cycle through a single multiplier, and a seed goes straight to
// placement. Results leave through an output register.
module streaming_graph_partition_assign (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_req_type_i,
  input  logic [15:0] in_vertex_id_i,
  input  logic [15:0] in_neighbor_id_i,
  input  logic        in_last_neighbor_i,
  input  logic [2:0]  in_seed_partition_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_placed_vertex_o,
  output logic [2:0]  out_chosen_partition_o,
  output logic [15:0] out_neighbors_inside_o,
  output logic [16:0] out_partition_size_o,
  output logic [31:0] out_inside_edge_total_o
);
  import sgpa_pkg::*;

  logic  clearing;
  logic  q_full;
  logic  q_push;
  logic  q_valid;
  logic  q_pop;
  item_t front_item;
  item_t head_item;

  sgpa_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_req_type_i       (in_req_type_i),
    .in_vertex_id_i      (in_vertex_id_i),
    .in_neighbor_id_i    (in_neighbor_id_i),
    .in_last_neighbor_i  (in_last_neighbor_i),
    .in_seed_partition_i (in_seed_partition_i),
    .clearing_i          (clearing),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_item_o            (front_item)
  );

  sgpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  sgpa_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .q_valid_i               (q_valid),
    .q_item_i                (head_item),
    .q_pop_o                 (q_pop),
    .clearing_o              (clearing),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_placed_vertex_o     (out_placed_vertex_o),
    .out_chosen_partition_o  (out_chosen_partition_o),
    .out_neighbors_inside_o  (out_neighbors_inside_o),
    .out_partition_size_o    (out_partition_size_o),
    .out_inside_edge_total_o (out_inside_edge_total_o)
  );

endmodule

>>> design/sgpa_checker.sv
// Port-level checks of the partition assigner, bound to its top level.
module sgpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_idx_i,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  in_req_type_i,
  input logic [15:0] in_vertex_id_i,
  input logic [15:0] in_neighbor_id_i,
  input logic        in_last_neighbor_i,
  input logic [2:0]  in_seed_partition_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] out_placed_vertex_o,
  input logic [2:0]  out_chosen_partition_o,
  input logic [15:0] out_neighbors_inside_o,
  input logic [16:0] out_partition_size_o,
  input logic [31:0] out_inside_edge_total_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_placed_vertex_o) &&
    $stable(out_chosen_partition_o) && $stable(out_partition_size_o) &&
    $stable(out_inside_edge_total_o))
    else $error("stalled result word changed");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_partition_size_o != 17'd0)
    else $error("placed partition reports zero size");

  a_edge_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_inside_edge_total_o >= {16'd0, out_neighbors_inside_o})
    else $error("inside-edge total below the neighbours just added");

  a_clear_stall: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o && !out_valid_o)
    else $error("input not stalled at the start of the clearing pass");

endmodule

bind streaming_graph_partition_assign sgpa_checker u_sgpa_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming graph partition assigner.
module testbench;
  import sgpa_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HALF_PERIOD    = 10;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int REPORT_LIMIT   = 100;
  localparam int RUN_SPAN       = 24;

  typedef struct packed {
    logic [ID_W-1:0]   vertex;
    logic [PW-1:0]     part;
    logic [CNT_W-1:0]  nb_count;
    logic [SIZE_W-1:0] size;
    logic [EDGE_W-1:0] edges;
  } placement_t;

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              cfg_we_i            = 1'b0;
  logic              cfg_idx_i           = CFG_ALPHA;
  logic [CFG_W-1:0]  cfg_data_i          = '0;
  logic              in_valid_i          = 1'b0;
  logic              in_stall_o;
  logic [1:0]        in_req_type_i       = REQ_UNUSED;
  logic [ID_W-1:0]   in_vertex_id_i      = '0;
  logic [ID_W-1:0]   in_neighbor_id_i    = '0;
  logic              in_last_neighbor_i  = 1'b0;
  logic [PW-1:0]     in_seed_partition_i = '0;
  logic              out_valid_o;
  logic              out_stall_i         = 1'b0;
  logic [ID_W-1:0]   out_placed_vertex_o;
  logic [PW-1:0]     out_chosen_partition_o;
  logic [CNT_W-1:0]  out_neighbors_inside_o;
  logic [SIZE_W-1:0] out_partition_size_o;
  logic [EDGE_W-1:0] out_inside_edge_total_o;

  // Predicted state of the block: owner_of holds partition + 1, or 0 when unplaced.
  bit [3:0]         owner_of [VERTICES];
  bit [CNT_W-1:0]   run_count [PARTS];
  bit [SIZE_W-1:0]  size_of [PARTS];
  bit [EDGE_W-1:0]  edges_of [PARTS];
  bit [ALPHA_W-1:0] alpha_cfg = ALPHA_RESET;
  bit [NPART_W-1:0] parts_cfg = PARTS_RESET;

  placement_t expected_placements [$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  bit         send_idle    = 1'b1;
  bit         recv_idle    = 1'b1;
  bit         hold_req     = 1'b0;

  streaming_graph_partition_assign dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .in_req_type_i           (in_req_type_i),
    .in_vertex_id_i          (in_vertex_id_i),
    .in_neighbor_id_i        (in_neighbor_id_i),
    .in_last_neighbor_i      (in_last_neighbor_i),
    .in_seed_partition_i     (in_seed_partition_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_placed_vertex_o     (out_placed_vertex_o),
    .out_chosen_partition_o  (out_chosen_partition_o),
    .out_neighbors_inside_o  (out_neighbors_inside_o),
    .out_partition_size_o    (out_partition_size_o),
    .out_inside_edge_total_o (out_inside_edge_total_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int best_partition();
    int     n;
    int     best;
    longint score;
    longint best_score;
    n = (parts_cfg == 0) ? 1 : (parts_cfg > PARTS) ? PARTS : parts_cfg;
    best = 0;
    best_score = 0;
    for (int p = 0; p < n; p++) begin
      score = longint'(run_count[p]) * 256
            - longint'(alpha_cfg) * (2 * longint'(size_of[p]) + 1);
      if (p == 0 || score > best_score) begin
        best_score = score;
        best = p;
      end
    end
    return best;
  endfunction

  function automatic void place_vertex(logic [ID_W-1:0] vertex, int part,
                                       logic [CNT_W-1:0] nb_count);
    logic [EDGE_W:0] sum;
    placement_t      r;
    owner_of[vertex] = 4'(part + 1);
    if (size_of[part] != '1) size_of[part]++;
    sum = edges_of[part] + nb_count;
    edges_of[part] = sum[EDGE_W] ? '1 : sum[EDGE_W-1:0];
    r.vertex   = vertex;
    r.part     = PW'(part);
    r.nb_count = nb_count;
    r.size     = size_of[part];
    r.edges    = edges_of[part];
    expected_placements.push_back(r);
    foreach (run_count[p]) run_count[p] = '0;
  endfunction

  function automatic void predict_placement(logic [1:0] req, logic [ID_W-1:0] vertex,
                                            logic [ID_W-1:0] neighbor, logic last,
                                            logic [PW-1:0] seed);
    int part;
    case (req)
      REQ_NEIGHBOR: begin
        if (owner_of[neighbor] != 0 && run_count[owner_of[neighbor] - 1] != '1)
          run_count[owner_of[neighbor] - 1]++;
        if (last) begin
          part = best_partition();
          place_vertex(vertex, part, run_count[part]);
        end
      end
      REQ_SEED: begin
        place_vertex(vertex, int'(seed), '0);
      end
      REQ_EMPTY: begin
        foreach (run_count[p]) run_count[p] = '0;
        place_vertex(vertex, best_partition(), '0);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 6) == 0) ? ID_W'($urandom_range(0, 65535))
                                       : ID_W'($urandom_range(0, 255));
  endfunction

  task automatic send_word(logic [1:0] req, logic [ID_W-1:0] vertex,
                           logic [ID_W-1:0] neighbor, logic last, logic [PW-1:0] seed);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    in_req_type_i       <= req;
    in_vertex_id_i      <= vertex;
    in_neighbor_id_i    <= neighbor;
    in_last_neighbor_i  <= last;
    in_seed_partition_i <= seed;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    predict_placement(req, vertex, neighbor, last, seed);
  endtask

  task automatic stop_offering();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_and_wait();
    stop_offering();
    while (expected_placements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ALPHA) alpha_cfg = data;
    else parts_cfg = data[NPART_W-1:0];
  endtask

  function automatic void check_field(string name, logic [EDGE_W-1:0] want,
                                      logic [EDGE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic test_directed();
    // With every partition empty the scores tie and the lowest partition wins.
    send_word(REQ_EMPTY, 16'h0000, 16'h0000, 1'b0, 3'd0);
    send_word(REQ_EMPTY, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7);
    send_word(REQ_SEED, 16'h1234, 16'hFFFF, 1'b1, 3'd7);
    send_word(REQ_SEED, 16'h0005, 16'h0000, 1'b0, 3'd0);
    // Placed, unplaced and unused-partition neighbours in one run; only the last vertex counts.
    send_word(REQ_NEIGHBOR, 16'd100, 16'h0000, 1'b0, 3'd5);
    send_word(REQ_NEIGHBOR, 16'd100, 16'hFFFF, 1'b0, 3'd2);
    send_word(REQ_NEIGHBOR, 16'd100, 16'h1234, 1'b0, 3'd0);
    send_word(REQ_NEIGHBOR, 16'd999, 16'd999, 1'b0, 3'd7);
    send_word(REQ_NEIGHBOR, 16'd100, 16'h0005, 1'b1, 3'd0);
    // Unfinished runs are dropped by a seed and by a vertex without neighbours.
    send_word(REQ_NEIGHBOR, 16'd200, 16'd100, 1'b0, 3'd0);
    send_word(REQ_SEED, 16'd201, 16'd100, 1'b0, 3'd3);
    send_word(REQ_NEIGHBOR, 16'd202, 16'd201, 1'b1, 3'd0);
    send_word(REQ_NEIGHBOR, 16'd300, 16'd202, 1'b0, 3'd0);
    send_word(REQ_EMPTY, 16'd301, 16'd0, 1'b0, 3'd0);
    // An unknown request inside a run leaves the run intact.
    send_word(REQ_NEIGHBOR, 16'd400, 16'd0, 1'b0, 3'd0);
    send_word(REQ_UNUSED, 16'd401, 16'd5, 1'b1, 3'd1);
    send_word(REQ_NEIGHBOR, 16'd400, 16'd5, 1'b1, 3'd0);
    // A vertex placed again moves without shrinking its old partition.
    send_word(REQ_SEED, 16'd0, 16'd0, 1'b0, 3'd4);
    send_word(REQ_NEIGHBOR, 16'd500, 16'd0, 1'b1, 3'd0);
    send_word(REQ_NEIGHBOR, 16'd501, 16'd501, 1'b1, 3'd0);
  endtask

  task automatic test_random_mix(int words, logic [ALPHA_W-1:0] alpha,
                                 logic [NPART_W-1:0] parts);
    int              sent;
    int              k;
    int              pick;
    logic [ID_W-1:0] vertex;
    drain_and_wait();
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_PARTS, CFG_W'(($urandom_range(0, 4095) << NPART_W) | parts));
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
      if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
      pick = $urandom_range(0, 99);
      vertex = pick_id();
      if (pick < 80) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          send_word(REQ_NEIGHBOR, ($urandom_range(0, 9) == 0) ? pick_id() : vertex,
                    pick_id(), (i == k - 1) && (pick < 72), PW'($urandom_range(0, 7)));
        sent += k;
      end else if (pick < 88) begin
        send_word(REQ_EMPTY, vertex, pick_id(), 1'($urandom_range(0, 1)),
                  PW'($urandom_range(0, 7)));
        sent++;
      end else if (pick < 96) begin
        send_word(REQ_SEED, vertex, pick_id(), 1'($urandom_range(0, 1)),
                  PW'($urandom_range(0, 7)));
        sent++;
      end else begin
        send_word(REQ_UNUSED, vertex, pick_id(), 1'($urandom_range(0, 1)),
                  PW'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_word((i % 2) ? REQ_SEED : REQ_EMPTY, pick_id(), pick_id(),
                1'($urandom_range(0, 1)), PW'($urandom_range(0, 7)));
    send_idle = 1'b1;
  endtask

  task automatic test_dense_run();
    drain_and_wait();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(CFG_ALPHA, '0);
    write_reg(CFG_PARTS, CFG_W'(PARTS));
    for (int v = 0; v < RUN_SPAN; v++) send_word(REQ_SEED, ID_W'(v), ID_W'(v), 1'b0, 3'd6);
    // Every neighbour of this run sits in one partition.
    for (int v = 0; v < RUN_SPAN; v++)
      send_word(REQ_NEIGHBOR, 16'hBEEF, ID_W'(v), v == RUN_SPAN - 1, 3'd0);
    for (int v = 0; v < RUN_SPAN; v++) send_word(REQ_SEED, ID_W'(v), 16'd0, 1'b1, 3'd6);
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_left == 0 && recv_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin : result_check
    placement_t want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $error("unexpected word for vertex %0d", out_placed_vertex_o);
      end else begin
        want = expected_placements.pop_front();
        check_field("placed_vertex", EDGE_W'(want.vertex), EDGE_W'(out_placed_vertex_o));
        check_field("chosen_partition", EDGE_W'(want.part),
                    EDGE_W'(out_chosen_partition_o));
        check_field("neighbors_inside", EDGE_W'(want.nb_count),
                    EDGE_W'(out_neighbors_inside_o));
        check_field("partition_size", EDGE_W'(want.size), EDGE_W'(out_partition_size_o));
        check_field("inside_edge_total", want.edges, out_inside_edge_total_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix(170, ALPHA_RESET, PARTS_RESET);
    test_random_mix(170, 16'd0, 4'd8);
    test_backpressure();
    test_random_mix(150, 16'hFFFF, 4'd1);
    test_random_mix(150, ALPHA_W'($urandom_range(0, 767)), 4'd0);
    test_random_mix(150, ALPHA_W'($urandom_range(0, 511)), 4'hF);
    test_random_mix(150, ALPHA_W'($urandom_range(0, 1023)), NPART_W'($urandom_range(2, 7)));
    test_dense_run();
    drain_and_wait();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
